>>> rtl/fmc_pkg.sv
`timescale 1ns / 1ps

package fmc_pkg;

   localparam int SAMPLE_WIDTH_DEF = 16;
   localparam int PHASE_WIDTH_DEF = 32;

   localparam int LEVEL_WIDTH = 15;
   localparam int STEP_WIDTH = 32;
   localparam int DEV_WIDTH = 31;
   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 32;

   localparam int FIXED_BITS = 15;
   localparam int SHORT_STEPS = 16;

   localparam logic [15:0] SIN_A = 16'd51472;
   localparam logic [14:0] SIN_B = 15'd21024;
   localparam logic [11:0] SIN_C = 12'd2320;
   localparam logic [14:0] AMP_Q15 = 15'd23170;
   localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
   localparam logic [15:0] HALF_TURN_Q15 = 16'h8000;

   localparam logic CMD_FLUSH = 1'b1;

   localparam logic [2:0] REG_ENABLE = 3'd0;
   localparam logic [2:0] REG_TONE_ENABLE = 3'd1;
   localparam logic [2:0] REG_TONE_LEVEL = 3'd2;
   localparam logic [2:0] REG_TONE_SCALE = 3'd3;
   localparam logic [2:0] REG_TONE_STEP = 3'd4;
   localparam logic [2:0] REG_DEV_STEP = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_MUL,
      ST_POST,
      ST_PUT
   } state_type;

   typedef enum logic [2:0] {
      OP_SQUARE,
      OP_CUBIC,
      OP_QUAD,
      OP_SINE,
      OP_LEVEL,
      OP_SCALE,
      OP_DEV,
      OP_AMP
   } op_type;

   typedef enum logic [1:0] {
      SRC_TONE,
      SRC_COS,
      SRC_SIN
   } src_type;

endpackage

>>> rtl/fm_modulator_ctcss.sv
`timescale 1ns / 1ps

// FM modulator with an optional subaudible tone. The req channel takes one word per
// sample: a command (process or flush) and an I/Q pair. The rsp channel returns one
// word of I/Q per processed sample; a flush clears both phase accumulators and
// returns nothing. The user must write the registers over the csr port only while
// the block is idle; the block itself does not enforce this. All products come
// from one shift-and-add multiplier that consumes one multiplier bit per cycle: a
// Q15 product uses a 16-bit multiplier and the deviation product a 31-bit one, and
// ST_POST then uses the result. A sine or cosine takes four such products. When
// disabled the block passes the sample straight through. A flush leaves the block
// idle. req_stall stays high until the result has moved to the output register, so
// the next word can be taken in the cycle after that. The output register holds a
// result while rsp_stall is high; the block may meanwhile accept and compute the
// next word, and it waits with that result until the register frees.
// Reset clears both phases, the registers to their defaults and the output valid.
module fm_modulator_ctcss
   import fmc_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
   parameter int PHASE_WIDTH = PHASE_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_cmd,
   input  logic signed [SAMPLE_WIDTH-1:0]   req_audio_i,
   input  logic signed [SAMPLE_WIDTH-1:0]   req_audio_q,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0]   rsp_out_i,
   output logic signed [SAMPLE_WIDTH-1:0]   rsp_out_q,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0]        csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0]        csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0]        csr_prdata,
   output logic                             csr_pready
);

   localparam int FRAC_BITS = SAMPLE_WIDTH - 1;
   localparam int OUT_SHIFT = 2 * FIXED_BITS - FRAC_BITS;
   localparam int MA = (SAMPLE_WIDTH + 1 > 18) ? SAMPLE_WIDTH + 1 : 18;
   localparam int PRW = MA + 1 + DEV_WIDTH;
   localparam int CNT_WIDTH = $clog2(DEV_WIDTH);

   logic                          enable_ff;
   logic                          tone_enable_ff;
   logic [LEVEL_WIDTH-1:0]        tone_level_ff;
   logic [LEVEL_WIDTH-1:0]        tone_scale_ff;
   logic [STEP_WIDTH-1:0]         tone_step_ff;
   logic [DEV_WIDTH-1:0]          dev_step_ff;

   state_type                     state_ff, state_in;
   op_type                        op_ff, op_in;
   src_type                       src_ff, src_in;
   logic [PHASE_WIDTH-1:0]        tone_phase_ff, tone_phase_in;
   logic [PHASE_WIDTH-1:0]        carrier_phase_ff, carrier_phase_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [CNT_WIDTH-1:0]          cnt_ff, cnt_in;
   logic                          long_ff, long_in;

   logic signed [SAMPLE_WIDTH-1:0] audio_ff, audio_in;
   logic [1:0]                    quad_ff, quad_in;
   logic [15:0]                   x_ff, x_in;
   logic [15:0]                   x2_ff, x2_in;
   logic signed [MA-1:0]          a_ff, a_in;
   logic signed [PRW-1:0]         p_ff, p_in;
   logic signed [SAMPLE_WIDTH-1:0] res_i_ff, res_i_in;
   logic signed [SAMPLE_WIDTH-1:0] res_q_ff, res_q_in;
   logic signed [SAMPLE_WIDTH-1:0] rsp_i_ff, rsp_q_ff;

   logic                          csr_write;
   logic [2:0]                    csr_index;

   logic                          load;
   logic signed [MA-1:0]          load_a;
   logic [DEV_WIDTH-1:0]          load_b;
   logic                          load_long;
   op_type                        load_op;
   logic                          put_go;

   logic [PHASE_WIDTH+31:0]       tone_wide;
   logic [PHASE_WIDTH+31:0]       carrier_wide;
   logic [PHASE_WIDTH+31:0]       step_wide;
   logic [31:0]                   sine_phase;
   logic [14:0]                   frac;
   logic [15:0]                   x_val;

   logic [MA+1:0]                 mul_sum;
   logic signed [PRW-1:0]         p_step;
   logic [CNT_WIDTH-1:0]          cnt_last;
   logic signed [PRW-1:0]         prod;
   logic signed [PRW-1:0]         prod_q15;
   logic signed [PRW-1:0]         prod_out;
   logic signed [PRW-1:0]         sat_top;
   logic signed [PHASE_WIDTH+31:0] dp_ext;
   logic signed [MA-1:0]          t_val;
   logic signed [MA-1:0]          u_val;
   logic signed [MA-1:0]          s_val;
   logic signed [MA-1:0]          sum_val;
   logic                          sat_fits;
   logic signed [SAMPLE_WIDTH-1:0] m_val;

   // Configuration port.
   assign csr_write = csr_psel & csr_penable & csr_pwrite;
   assign csr_index = csr_paddr[CSR_ADDR_WIDTH-1:2];
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         tone_enable_ff <= 1'b0;
         tone_level_ff <= '0;
         tone_scale_ff <= '1;
         tone_step_ff <= '0;
         dev_step_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_ENABLE:      enable_ff <= csr_pwdata[0];
            REG_TONE_ENABLE: tone_enable_ff <= csr_pwdata[0];
            REG_TONE_LEVEL:  tone_level_ff <= csr_pwdata[LEVEL_WIDTH-1:0];
            REG_TONE_SCALE:  tone_scale_ff <= csr_pwdata[LEVEL_WIDTH-1:0];
            REG_TONE_STEP:   tone_step_ff <= csr_pwdata[STEP_WIDTH-1:0];
            REG_DEV_STEP:    dev_step_ff <= csr_pwdata[DEV_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_ENABLE:      csr_prdata = CSR_DATA_WIDTH'(enable_ff);
         REG_TONE_ENABLE: csr_prdata = CSR_DATA_WIDTH'(tone_enable_ff);
         REG_TONE_LEVEL:  csr_prdata = CSR_DATA_WIDTH'(tone_level_ff);
         REG_TONE_SCALE:  csr_prdata = CSR_DATA_WIDTH'(tone_scale_ff);
         REG_TONE_STEP:   csr_prdata = CSR_DATA_WIDTH'(tone_step_ff);
         REG_DEV_STEP:    csr_prdata = CSR_DATA_WIDTH'(dev_step_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // Phase views: the top 32 bits of a phase, zero filled when the phase is narrower.
   assign tone_wide = {tone_phase_ff, 32'b0};
   assign carrier_wide = {carrier_phase_ff, 32'b0};
   assign step_wide = {{PHASE_WIDTH{1'b0}}, tone_step_ff};

   always_comb begin
      case (src_ff)
         SRC_TONE: sine_phase = tone_wide[PHASE_WIDTH+31 -: 32] + QUARTER_TURN;
         SRC_COS:  sine_phase = carrier_wide[PHASE_WIDTH+31 -: 32] + QUARTER_TURN;
         default:  sine_phase = carrier_wide[PHASE_WIDTH+31 -: 32];
      endcase
   end

   assign frac = sine_phase[29:15];
   assign x_val = sine_phase[30] ? (HALF_TURN_Q15 - {1'b0, frac}) : {1'b0, frac};

   // Serial multiplier: one bit of the unsigned multiplier per cycle, taken from the
   // bottom of p_ff while the partial product shifts in from the top.
   assign mul_sum = {p_ff[PRW-1], p_ff[PRW-1:DEV_WIDTH]}
                  + (p_ff[0] ? {a_ff[MA-1], a_ff[MA-1], a_ff} : '0);
   assign p_step = $signed({mul_sum, p_ff[DEV_WIDTH-1:1]});
   assign cnt_last = long_ff ? CNT_WIDTH'(DEV_WIDTH - 1) : CNT_WIDTH'(SHORT_STEPS - 1);

   assign prod = long_ff ? p_ff : (p_ff >>> (DEV_WIDTH - SHORT_STEPS));
   assign prod_q15 = prod >>> FIXED_BITS;
   assign prod_out = prod >>> OUT_SHIFT;
   assign dp_ext = (PHASE_WIDTH + 32)'(prod >>> FRAC_BITS);

   assign t_val = $signed(MA'({1'b0, SIN_B}) - prod_q15[MA-1:0]);
   assign u_val = $signed(MA'(SIN_A) - prod_q15[MA-1:0]);
   assign s_val = $signed(quad_ff[1] ? (~prod_q15[MA-1:0] + 1'b1) : prod_q15[MA-1:0]);
   assign sum_val = MA'(audio_ff) + $signed(prod_out[MA-1:0]);

   assign sat_top = prod_q15 >>> FRAC_BITS;
   assign sat_fits = (sat_top == '0) || (sat_top == '1);
   assign m_val = sat_fits ? prod_q15[SAMPLE_WIDTH-1:0]
                : (prod_q15[PRW-1] ? $signed({1'b1, {FRAC_BITS{1'b0}}})
                                   : $signed({1'b0, {FRAC_BITS{1'b1}}}));

   assign put_go = (state_ff == ST_PUT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      src_in = src_ff;
      tone_phase_in = tone_phase_ff;
      carrier_phase_in = carrier_phase_ff;
      audio_in = audio_ff;
      quad_in = quad_ff;
      x_in = x_ff;
      x2_in = x2_ff;
      a_in = a_ff;
      p_in = p_ff;
      cnt_in = cnt_ff;
      long_in = long_ff;
      res_i_in = res_i_ff;
      res_q_in = res_q_ff;
      load = 1'b0;
      load_a = '0;
      load_b = '0;
      load_long = 1'b0;
      load_op = op_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               audio_in = req_audio_i;
               if (req_cmd == CMD_FLUSH) begin
                  tone_phase_in = '0;
                  carrier_phase_in = '0;
               end else if (!enable_ff) begin
                  res_i_in = req_audio_i;
                  res_q_in = req_audio_q;
                  state_in = ST_PUT;
               end else if (tone_enable_ff) begin
                  tone_phase_in = tone_phase_ff + step_wide[PHASE_WIDTH-1:0];
                  src_in = SRC_TONE;
                  state_in = ST_SETUP;
               end else begin
                  load = 1'b1;
                  load_a = MA'(req_audio_i);
                  load_b = dev_step_ff;
                  load_long = 1'b1;
                  load_op = OP_DEV;
               end
            end
         end
         ST_SETUP: begin
            quad_in = sine_phase[31:30];
            x_in = x_val;
            load = 1'b1;
            load_a = MA'($signed({1'b0, x_val}));
            load_b = DEV_WIDTH'(x_val);
            load_op = OP_SQUARE;
         end
         ST_MUL: begin
            p_in = p_step;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == cnt_last) begin
               state_in = ST_POST;
            end
         end
         ST_POST: begin
            load = 1'b1;
            case (op_ff)
               OP_SQUARE: begin
                  x2_in = prod_q15[15:0];
                  load_a = MA'($signed({1'b0, prod_q15[15:0]}));
                  load_b = DEV_WIDTH'(SIN_C);
                  load_op = OP_CUBIC;
               end
               OP_CUBIC: begin
                  load_a = t_val;
                  load_b = DEV_WIDTH'(x2_ff);
                  load_op = OP_QUAD;
               end
               OP_QUAD: begin
                  load_a = u_val;
                  load_b = DEV_WIDTH'(x_ff);
                  load_op = OP_SINE;
               end
               OP_SINE: begin
                  load_a = s_val;
                  if (src_ff == SRC_TONE) begin
                     load_b = DEV_WIDTH'(tone_level_ff);
                     load_op = OP_LEVEL;
                  end else begin
                     load_b = DEV_WIDTH'(AMP_Q15);
                     load_op = OP_AMP;
                  end
               end
               OP_LEVEL: begin
                  load_a = sum_val;
                  load_b = DEV_WIDTH'(tone_scale_ff);
                  load_op = OP_SCALE;
               end
               OP_SCALE: begin
                  load_a = MA'(m_val);
                  load_b = dev_step_ff;
                  load_long = 1'b1;
                  load_op = OP_DEV;
               end
               OP_DEV: begin
                  load = 1'b0;
                  carrier_phase_in = carrier_phase_ff + dp_ext[PHASE_WIDTH-1:0];
                  src_in = SRC_COS;
                  state_in = ST_SETUP;
               end
               OP_AMP: begin
                  load = 1'b0;
                  if (src_ff == SRC_COS) begin
                     res_i_in = prod_out[SAMPLE_WIDTH-1:0];
                     src_in = SRC_SIN;
                     state_in = ST_SETUP;
                  end else begin
                     res_q_in = prod_out[SAMPLE_WIDTH-1:0];
                     state_in = ST_PUT;
                  end
               end
               default: begin
                  load = 1'b0;
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_PUT: begin
            if (put_go) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (load) begin
         a_in = load_a;
         p_in = $signed({{(MA + 1){1'b0}}, load_b});
         cnt_in = '0;
         long_in = load_long;
         op_in = load_op;
         state_in = ST_MUL;
      end

      rsp_valid_in = put_go | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff <= OP_SQUARE;
         src_ff <= SRC_TONE;
         tone_phase_ff <= '0;
         carrier_phase_ff <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff <= '0;
         long_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff <= op_in;
         src_ff <= src_in;
         tone_phase_ff <= tone_phase_in;
         carrier_phase_ff <= carrier_phase_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff <= cnt_in;
         long_ff <= long_in;
      end
   end

   always_ff @(posedge clock) begin
      audio_ff <= audio_in;
      quad_ff <= quad_in;
      x_ff <= x_in;
      x2_ff <= x2_in;
      a_ff <= a_in;
      p_ff <= p_in;
      res_i_ff <= res_i_in;
      res_q_ff <= res_q_in;
      if (put_go) begin
         rsp_i_ff <= res_i_ff;
         rsp_q_ff <= res_q_ff;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_i = rsp_i_ff;
   assign rsp_out_q = rsp_q_ff;

endmodule

>>> rtl/fmc_checker.sv
`timescale 1ns / 1ps

module fmc_checker
   import fmc_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic                           req_cmd,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic signed [SAMPLE_WIDTH-1:0] rsp_out_i,
   input logic signed [SAMPLE_WIDTH-1:0] rsp_out_q
);

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("outputs not quiet after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_i) && $stable(rsp_out_q))
      else $error("stalled result word changed or dropped");

   a_flush_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_cmd == CMD_FLUSH) && !rsp_valid |=> !rsp_valid)
      else $error("flush word produced a result");

   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_cmd != CMD_FLUSH) |=> req_stall)
      else $error("sample word accepted without becoming busy");

   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared while the block was idle");

endmodule

bind fm_modulator_ctcss fmc_checker #(
   .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_fmc_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .req_cmd(req_cmd),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_out_i(rsp_out_i),
   .rsp_out_q(rsp_out_q)
);

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;
   import fmc_pkg::*;

   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int SETTLE_CYCLES = 16;
   localparam int TAIL_CYCLES = 400;
   localparam int SETS_PER_PHASE = 4;
   localparam int WORDS_PER_SET = 65;
   localparam int HOLD_OFF_CYCLES = 3000;
   localparam logic CMD_SAMPLE = 1'b0;
   localparam longint K_A = 51472;
   localparam longint K_B = 21024;
   localparam longint K_C = 2320;
   localparam longint K_AMP = 23170;

   typedef struct packed {
      logic signed [15:0] i;
      logic signed [15:0] q;
   } iq_word_type;

   typedef struct {
      bit                 is_cfg;
      logic [2:0]         idx;
      logic [31:0]        value;
      logic               cmd;
      logic signed [15:0] ai;
      logic signed [15:0] aq;
      bit                 typed;
      iq_word_type        want;
   } stim_row_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic req_cmd;
   logic signed [15:0] req_audio_i;
   logic signed [15:0] req_audio_q;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [15:0] rsp_out_i;
   logic signed [15:0] rsp_out_q;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic csr_pready;

   logic        mod_enable;
   logic        mod_tone_enable;
   logic [14:0] mod_tone_level;
   logic [14:0] mod_tone_scale;
   logic [31:0] mod_tone_step;
   logic [30:0] mod_dev_step;
   logic [31:0] tone_acc;
   logic [31:0] carrier_acc;

   iq_word_type pending_iq[$];
   stim_row_type directed[$];
   int send_idle_pct;
   int recv_idle_pct;
   int hold_reqs;
   int words_sent;
   int flushes_sent;
   int iq_seen;
   int mismatches;

   fm_modulator_ctcss dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cmd(req_cmd),
      .req_audio_i(req_audio_i),
      .req_audio_q(req_audio_q),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_i(rsp_out_i),
      .rsp_out_q(rsp_out_q),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("[fm_modulator_ctcss] ERROR");
      $finish;
   end

   function automatic longint sine_q15(input logic [31:0] p);
      longint f, x, x2, t, u, s;
      f = longint'(p[29:15]);
      x = p[30] ? 32768 - f : f;
      x2 = (x * x) >>> 15;
      t = K_B - ((K_C * x2) >>> 15);
      u = K_A - ((t * x2) >>> 15);
      s = (u * x) >>> 15;
      return p[31] ? -s : s;
   endfunction

   function automatic longint cosine_q15(input logic [31:0] p);
      logic [31:0] shifted;
      shifted = p + QUARTER_TURN;
      return sine_q15(shifted);
   endfunction

   function automatic bit next_iq(input logic cmd, input logic signed [15:0] ai,
                                  input logic signed [15:0] aq, output iq_word_type res);
      longint m, term, dp, ci, cq;
      res = '0;
      if (cmd == CMD_FLUSH) begin
         tone_acc = '0;
         carrier_acc = '0;
         return 1'b0;
      end
      if (!mod_enable) begin
         res.i = ai;
         res.q = aq;
         return 1'b1;
      end
      m = longint'(ai);
      if (mod_tone_enable) begin
         tone_acc = tone_acc + mod_tone_step;
         term = (longint'(mod_tone_level) * cosine_q15(tone_acc)) >>> 15;
         m = ((m + term) * longint'(mod_tone_scale)) >>> 15;
         if (m > 32767) m = 32767;
         if (m < -32768) m = -32768;
      end
      dp = (m * longint'(mod_dev_step)) >>> 15;
      carrier_acc = carrier_acc + dp[31:0];
      ci = (K_AMP * cosine_q15(carrier_acc)) >>> 15;
      cq = (K_AMP * sine_q15(carrier_acc)) >>> 15;
      res.i = ci[15:0];
      res.q = cq[15:0];
      return 1'b1;
   endfunction

   function automatic stim_row_type cfg_row(input logic [2:0] idx, input logic [31:0] value);
      stim_row_type r;
      r = '{default: '0};
      r.is_cfg = 1'b1;
      r.idx = idx;
      r.value = value;
      return r;
   endfunction

   function automatic stim_row_type word_row(input logic cmd, input logic signed [15:0] ai,
                                             input logic signed [15:0] aq, input bit typed,
                                             input logic signed [15:0] ei,
                                             input logic signed [15:0] eq);
      stim_row_type r;
      r = '{default: '0};
      r.cmd = cmd;
      r.ai = ai;
      r.aq = aq;
      r.typed = typed;
      r.want.i = ei;
      r.want.q = eq;
      return r;
   endfunction

   function automatic logic [31:0] pick_reg(input int w);
      logic [31:0] lim, v;
      lim = (w == 32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 32'd1);
      case ($urandom_range(3))
         0: v = '0;
         1: v = lim;
         default: v = $urandom & lim;
      endcase
      if (w < 32 && $urandom_range(1) == 1) v = v | ($urandom & ~lim);
      return v;
   endfunction

   function automatic logic signed [15:0] pick_audio();
      case ($urandom_range(19))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return 16'sh0000;
         default: return 16'($urandom);
      endcase
   endfunction

   always @(posedge clock) begin
      iq_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         iq_seen++;
         if (pending_iq.size() == 0) begin
            $error("unexpected I/Q word: out_i %0d out_q %0d", rsp_out_i, rsp_out_q);
            mismatches++;
         end else begin
            want = pending_iq.pop_front();
            if (rsp_out_i !== want.i) begin
               $error("out_i expected %0d actual %0d", want.i, rsp_out_i);
               mismatches++;
            end
            if (rsp_out_q !== want.q) begin
               $error("out_q expected %0d actual %0d", want.q, rsp_out_q);
               mismatches++;
            end
         end
      end
   end

   initial begin
      int hold_left;
      int hold_seen;
      rsp_stall = 1'b0;
      hold_left = 0;
      hold_seen = 0;
      forever begin
         @(negedge clock);
         if (hold_reqs != hold_seen) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall = 1'b1;
            hold_left--;
         end else begin
            rsp_stall = ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = {idx, 2'b00};
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      case (idx)
         REG_ENABLE: mod_enable = value[0];
         REG_TONE_ENABLE: mod_tone_enable = value[0];
         REG_TONE_LEVEL: mod_tone_level = value[14:0];
         REG_TONE_SCALE: mod_tone_scale = value[14:0];
         REG_TONE_STEP: mod_tone_step = value;
         REG_DEV_STEP: mod_dev_step = value[30:0];
         default: ;
      endcase
   endtask

   task automatic send_word(input logic cmd, input logic signed [15:0] ai,
                            input logic signed [15:0] aq, input bit typed,
                            input iq_word_type want);
      iq_word_type pred;
      bit has_iq;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_cmd = cmd;
      req_audio_i = ai;
      req_audio_q = aq;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
      if (cmd == CMD_FLUSH) flushes_sent++;
      has_iq = next_iq(cmd, ai, aq, pred);
      if (has_iq) pending_iq.push_back(typed ? want : pred);
   endtask

   task automatic drain(input int extra);
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_iq.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic random_setup();
      logic [31:0] v;
      v = ($urandom & ~32'd1) | ($urandom_range(9) < 8);
      csr_write(REG_ENABLE, v);
      v = ($urandom & ~32'd1) | $urandom_range(1);
      csr_write(REG_TONE_ENABLE, v);
      csr_write(REG_TONE_LEVEL, pick_reg(LEVEL_WIDTH));
      csr_write(REG_TONE_SCALE, pick_reg(LEVEL_WIDTH));
      csr_write(REG_TONE_STEP, pick_reg(STEP_WIDTH));
      csr_write(REG_DEV_STEP, pick_reg(DEV_WIDTH));
   endtask

   initial begin
      stim_row_type r;
      logic cmd;
      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd = CMD_SAMPLE;
      req_audio_i = '0;
      req_audio_q = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      hold_reqs = 0;
      words_sent = 0;
      flushes_sent = 0;
      iq_seen = 0;
      mismatches = 0;
      send_idle_pct = 23;
      recv_idle_pct = 77;
      mod_enable = 1'b0;
      mod_tone_enable = 1'b0;
      mod_tone_level = '0;
      mod_tone_scale = 15'd32767;
      mod_tone_step = '0;
      mod_dev_step = '0;
      tone_acc = '0;
      carrier_acc = '0;

      // After reset the block is disabled and passes I/Q through.
      directed.push_back(word_row(CMD_SAMPLE, 16'sh7FFF, 16'sh8000, 1, 16'sh7FFF, 16'sh8000));
      directed.push_back(word_row(CMD_SAMPLE, 16'sh8000, 16'sh7FFF, 1, 16'sh8000, 16'sh7FFF));
      directed.push_back(word_row(CMD_SAMPLE, 16'sh0000, 16'sh0000, 1, 16'sh0000, 16'sh0000));
      directed.push_back(word_row(CMD_SAMPLE, -16'sd1, 16'sd1, 1, -16'sd1, 16'sd1));
      directed.push_back(word_row(CMD_FLUSH, 16'sh1234, 16'sh4321, 0, 0, 0));
      // With no deviation the carrier stays at zero phase.
      directed.push_back(cfg_row(REG_ENABLE, 32'hFFFF_FFFF));
      directed.push_back(word_row(CMD_SAMPLE, 16'sh7FFF, -16'sd1, 1, 16'sd23170, 16'sd0));
      directed.push_back(word_row(CMD_SAMPLE, 16'sh8000, 16'sd5, 1, 16'sd23170, 16'sd0));
      directed.push_back(cfg_row(REG_DEV_STEP, 32'hFFFF_FFFF));
      directed.push_back(word_row(CMD_SAMPLE, 16'sh7FFF, 16'sd0, 0, 0, 0));
      directed.push_back(word_row(CMD_SAMPLE, 16'sh8000, 16'sd0, 0, 0, 0));
      directed.push_back(word_row(CMD_SAMPLE, 16'sd12345, 16'sd0, 0, 0, 0));
      directed.push_back(word_row(CMD_FLUSH, 16'sd0, 16'sd0, 0, 0, 0));
      directed.push_back(word_row(CMD_SAMPLE, 16'sd0, 16'sd0, 1, 16'sd23170, 16'sd0));
      directed.push_back(cfg_row(REG_TONE_ENABLE, 32'd1));
      directed.push_back(cfg_row(REG_TONE_LEVEL, 32'hFFFF_FFFF));
      directed.push_back(cfg_row(REG_TONE_STEP, 32'hFFFF_FFFF));
      directed.push_back(cfg_row(REG_TONE_SCALE, 32'hFFFF_8000));
      directed.push_back(word_row(CMD_SAMPLE, 16'sh7FFF, 16'sd0, 1, 16'sd23170, 16'sd0));
      directed.push_back(cfg_row(REG_TONE_SCALE, 32'h0000_7FFF));
      directed.push_back(word_row(CMD_SAMPLE, 16'sh7FFF, 16'sd0, 0, 0, 0));
      directed.push_back(word_row(CMD_SAMPLE, 16'sh8000, 16'sd0, 0, 0, 0));
      directed.push_back(word_row(CMD_SAMPLE, 16'sd0, 16'sd0, 0, 0, 0));
      directed.push_back(word_row(CMD_FLUSH, 16'sd0, 16'sd0, 0, 0, 0));
      directed.push_back(word_row(CMD_SAMPLE, 16'sd100, 16'sd0, 0, 0, 0));

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[n]) begin
         r = directed[n];
         if (r.is_cfg) begin
            drain(SETTLE_CYCLES);
            csr_write(r.idx, r.value);
         end else begin
            send_word(r.cmd, r.ai, r.aq, r.typed, r.want);
         end
      end

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 77 : 0;
         recv_idle_pct = (phase == 0) ? 77 : (phase == 1) ? 23 : 0;
         for (int set = 0; set < SETS_PER_PHASE; set++) begin
            drain(SETTLE_CYCLES);
            random_setup();
            // The receiver holds off long enough for the block to back up its input.
            if (phase == 2 && set == 0) hold_reqs++;
            for (int k = 0; k < WORDS_PER_SET; k++) begin
               cmd = ($urandom_range(99) < 3) ? CMD_FLUSH : CMD_SAMPLE;
               send_word(cmd, pick_audio(), pick_audio(), 0, '0);
            end
         end
      end

      drain(TAIL_CYCLES);
      $display("Sent %0d words (%0d flushes) and checked %0d I/Q words.",
               words_sent, flushes_sent, iq_seen);
      $display("Covered bypass, modulation with and without the tone, and register extremes.");
      if (mismatches == 0) begin
         $display("[fm_modulator_ctcss] OK");
      end else begin
         $display("[fm_modulator_ctcss] ERROR");
      end
      $finish;
   end

endmodule
